>>> hw/rtl/sha256_byte_stream_hasher_unit_macros.svh
// assertion macros used by the checker file
// depends on nothing
`ifndef SHA256_BYTE_STREAM_HASHER_UNIT_MACROS_SVH
`define SHA256_BYTE_STREAM_HASHER_UNIT_MACROS_SVH
// implication checked on every clock edge outside reset
`define SHA_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// next-cycle implication checked outside reset
`define SHA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

>>> hw/rtl/sha_pkg.sv
// package for the sha-256 byte stream hasher: types, constants, round functions
// depends on nothing
package sha_pkg;

   localparam int unsigned BufDepth = 16;
   localparam int unsigned BufAddrW = 4;

   localparam logic [1:0] OP_RESTART = 2'd0;
   localparam logic [1:0] OP_ABSORB  = 2'd1;
   localparam logic [1:0] OP_FINISH  = 2'd2;

   typedef struct packed {
      logic [1:0] op;
      logic [7:0] msg_byte;
   } req_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last_word;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD,
      ST_ROUND,
      ST_UPDATE,
      ST_EMIT
   } state_type;

   function automatic logic [31:0] init_h(input logic [2:0] idx);
      logic [31:0] v;
      begin
         unique case (idx)
            3'd0: v = 32'h6a09e667;
            3'd1: v = 32'hbb67ae85;
            3'd2: v = 32'h3c6ef372;
            3'd3: v = 32'ha54ff53a;
            3'd4: v = 32'h510e527f;
            3'd5: v = 32'h9b05688c;
            3'd6: v = 32'h1f83d9ab;
            default: v = 32'h5be0cd19;
         endcase
         return v;
      end
   endfunction

   function automatic logic [31:0] round_k(input logic [5:0] idx);
      logic [31:0] k [64];
      begin
         k = '{
            32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
            32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
            32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
            32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
            32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
            32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
            32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
            32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
            32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
            32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
            32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
            32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
            32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
            32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
            32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
            32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
         return k[idx];
      end
   endfunction

   function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
      return (x >> n) | (x << (32 - n));
   endfunction

   function automatic logic [31:0] sig0(input logic [31:0] x);
      return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
   endfunction

   function automatic logic [31:0] sig1(input logic [31:0] x);
      return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
   endfunction

   function automatic logic [31:0] bsig0(input logic [31:0] x);
      return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
   endfunction

   function automatic logic [31:0] bsig1(input logic [31:0] x);
      return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
   endfunction

endpackage

>>> hw/rtl/sha256_byte_stream_hasher_unit.sv
// sha-256 byte stream hasher top level
// depends on sha_pkg and sha_ram
//
// usage
//  - req channel (valid/ready) carries one request: op and msg_byte
//    op restart clears the chaining state, op absorb appends one byte,
//    op finish pads the message and returns eight digest words
//  - rsp channel (valid/ready) returns digest words h0..h7, last_word on h7
//  - absorb is taken while idle; the 64th byte of a block starts a compression:
//    a ram read, 64 rounds and a chaining update
//  - finish writes 9..72 pad and length bytes, one per cycle, runs one or two
//    compressions, then sends eight words, one per cycle while the receiver
//    takes them
//  - the rate is set by the single round unit: one round per cycle
//  - the message words sit in a 16 x 32 ram; rounds 0..15 read it, later
//    rounds take the schedule from a 16-word register window
//  - a stalled receiver holds the current word; no request is taken until
//    the last word is taken
//  - reset (synchronous, active high) returns the chaining words to the
//    initial values and clears the byte and bit counts
//  - unused op code 3 is accepted and ignored
module sha256_byte_stream_hasher_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  sha_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output sha_pkg::rsp_type rsp_payload
);

   // control state
   sha_pkg::state_type state_ff, state_in;
   logic [5:0]  fill_ff, fill_in;        // bytes pending
   logic [63:0] bits_ff, bits_in;        // message length in bits
   logic [5:0]  round_ff, round_in;      // round counter
   logic        finish_ff, finish_in;    // compression belongs to a finish
   logic        last_blk_ff, last_blk_in;// compression is the length block
   logic [2:0]  emit_ff, emit_in;        // digest word being sent

   // chaining and working registers
   logic [31:0] h_ff [8];
   logic [31:0] h_in [8];
   logic [31:0] v_ff [8];
   logic [31:0] v_in [8];

   // schedule window held in registers, loaded from the ram in rounds 0..15
   logic [31:0] w_ff [16];
   logic [31:0] w_in [16];
   logic [23:0] part_ff, part_in;        // partial word being assembled

   // message word ram: holds the packed words of the block
   logic                          ram_we;
   logic [sha_pkg::BufAddrW-1:0]  ram_wa;
   logic [31:0]                   ram_wd;
   logic [sha_pkg::BufAddrW-1:0]  ram_ra;
   logic [31:0]                   ram_rd;

   sha_ram #(.Width(32), .Depth(sha_pkg::BufDepth)) u_msg_ram (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_wa),
      .wr_data(ram_wd),
      .rd_addr(ram_ra),
      .rd_data(ram_rd)
   );

   logic        take_req;
   logic [7:0]  byte_val;
   logic        byte_wr;
   logic [31:0] wcur;
   logic [31:0] wnew;
   logic [31:0] t1, t2;
   logic        ram_pref_ff;

   assign take_req = req_valid && req_ready;

   // byte into the current word; a word is written to the ram on its fourth byte
   always_comb begin
      byte_wr  = 1'b0;
      byte_val = 8'h00;
      if (state_ff == sha_pkg::ST_IDLE && take_req && req_payload.op == sha_pkg::OP_ABSORB) begin
         byte_wr  = 1'b1;
         byte_val = req_payload.msg_byte;
      end else if (state_ff == sha_pkg::ST_PAD) begin
         byte_wr = 1'b1;
         if (!finish_ff) begin
            byte_val = 8'h80;
         end else if (last_blk_ff && fill_ff >= 6'd56) begin
            byte_val = bits_ff[8'd63 - {2'b00, fill_ff[2:0], 3'b000} -: 8];
         end else begin
            byte_val = 8'h00;
         end
      end
   end

   // read address runs one round ahead to cover the ram read latency
   always_comb begin
      ram_we = byte_wr && (fill_ff[1:0] == 2'b11);
      ram_wa = fill_ff[5:2];
      ram_wd = {part_ff, byte_val};
      ram_ra = round_in[3:0];
   end

   // round datapath
   always_comb begin
      if (round_ff < 6'd16) begin
         wcur = ram_rd;
      end else begin
         wcur = w_ff[0] + w_ff[9] + sha_pkg::sig0(w_ff[1]) + sha_pkg::sig1(w_ff[14]);
      end
      wnew = wcur;
      t1 = v_ff[7] + sha_pkg::bsig1(v_ff[4]) + (v_ff[6] ^ (v_ff[4] & (v_ff[5] ^ v_ff[6])))
         + sha_pkg::round_k(round_ff) + wcur;
      t2 = sha_pkg::bsig0(v_ff[0])
         + ((v_ff[0] & v_ff[1]) | (v_ff[2] & (v_ff[0] | v_ff[1])));
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sha_pkg::ST_IDLE: begin
            if (take_req) begin
               if (req_payload.op == sha_pkg::OP_ABSORB && fill_ff == 6'd63) begin
                  state_in = sha_pkg::ST_ROUND;
               end else if (req_payload.op == sha_pkg::OP_FINISH) begin
                  state_in = sha_pkg::ST_PAD;
               end
            end
         end
         sha_pkg::ST_PAD: begin
            if (fill_ff == 6'd63) begin
               state_in = sha_pkg::ST_ROUND;
            end else if (!last_blk_ff && fill_ff == 6'd55 && finish_ff) begin
               state_in = sha_pkg::ST_PAD;
            end
         end
         sha_pkg::ST_ROUND: begin
            if (!ram_pref_ff) begin
               state_in = sha_pkg::ST_ROUND;
            end else if (round_ff == 6'd63) begin
               state_in = sha_pkg::ST_UPDATE;
            end
         end
         sha_pkg::ST_UPDATE: begin
            if (!finish_ff) begin
               state_in = sha_pkg::ST_IDLE;
            end else if (last_blk_ff) begin
               state_in = sha_pkg::ST_EMIT;
            end else begin
               state_in = sha_pkg::ST_PAD;
            end
         end
         sha_pkg::ST_EMIT: begin
            if (rsp_ready && emit_ff == 3'd7) begin
               state_in = sha_pkg::ST_IDLE;
            end
         end
         default: state_in = sha_pkg::ST_IDLE;
      endcase
   end

   // data path and counters
   always_comb begin
      fill_in     = fill_ff;
      bits_in     = bits_ff;
      round_in    = round_ff;
      finish_in   = finish_ff;
      last_blk_in = last_blk_ff;
      emit_in     = emit_ff;
      part_in     = part_ff;
      h_in        = h_ff;
      v_in        = v_ff;
      w_in        = w_ff;

      if (byte_wr) begin
         part_in = {part_ff[15:0], byte_val};
         fill_in = fill_ff + 6'd1;
      end

      unique case (state_ff)
         sha_pkg::ST_IDLE: begin
            if (take_req) begin
               if (req_payload.op == sha_pkg::OP_RESTART) begin
                  fill_in = '0;
                  bits_in = '0;
                  for (int i = 0; i < 8; i++) h_in[i] = sha_pkg::init_h(3'(i));
               end else if (req_payload.op == sha_pkg::OP_ABSORB) begin
                  bits_in = bits_ff + 64'd8;
                  if (fill_ff == 6'd63) begin
                     finish_in = 1'b0;
                     round_in  = '0;
                     v_in      = h_ff;
                  end
               end else if (req_payload.op == sha_pkg::OP_FINISH) begin
                  finish_in   = 1'b1;
                  last_blk_in = (fill_ff < 6'd56);
               end
            end
         end
         sha_pkg::ST_PAD: begin
            // the first pad byte (0x80) is written with finish_ff low below
            if (fill_ff == 6'd63) begin
               round_in = '0;
               v_in     = h_ff;
            end
         end
         sha_pkg::ST_ROUND: begin
            if (ram_pref_ff) begin
               for (int i = 0; i < 15; i++) w_in[i] = w_ff[i+1];
               w_in[15] = wnew;
               v_in[7] = v_ff[6];
               v_in[6] = v_ff[5];
               v_in[5] = v_ff[4];
               v_in[4] = v_ff[3] + t1;
               v_in[3] = v_ff[2];
               v_in[2] = v_ff[1];
               v_in[1] = v_ff[0];
               v_in[0] = t1 + t2;
               round_in = round_ff + 6'd1;
            end
         end
         sha_pkg::ST_UPDATE: begin
            for (int i = 0; i < 8; i++) h_in[i] = h_ff[i] + v_ff[i];
            if (finish_ff && !last_blk_ff) begin
               last_blk_in = 1'b1;
            end
            emit_in = '0;
         end
         sha_pkg::ST_EMIT: begin
            if (rsp_ready) begin
               emit_in = emit_ff + 3'd1;
               if (emit_ff == 3'd7) begin
                  fill_in = '0;
                  bits_in = '0;
                  for (int i = 0; i < 8; i++) h_in[i] = sha_pkg::init_h(3'(i));
               end
            end
         end
         default: ;
      endcase
   end

   // pad flag: 0x80 goes first, zeros and length follow
   logic pad_first_ff;

   // outputs
   always_comb begin
      req_ready = (state_ff == sha_pkg::ST_IDLE);
      rsp_valid = (state_ff == sha_pkg::ST_EMIT);
      rsp_payload.digest_word = h_ff[emit_ff];
      rsp_payload.word_index  = emit_ff;
      rsp_payload.last_word   = (emit_ff == 3'd7);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sha_pkg::ST_IDLE;
         fill_ff      <= '0;
         bits_ff      <= '0;
         round_ff     <= '0;
         finish_ff    <= 1'b0;
         last_blk_ff  <= 1'b0;
         emit_ff      <= '0;
         ram_pref_ff  <= 1'b0;
         pad_first_ff <= 1'b0;
         for (int i = 0; i < 8; i++) h_ff[i] <= sha_pkg::init_h(3'(i));
      end else begin
         state_ff    <= state_in;
         fill_ff     <= fill_in;
         bits_ff     <= bits_in;
         round_ff    <= round_in;
         last_blk_ff <= last_blk_in;
         emit_ff     <= emit_in;
         h_ff        <= h_in;
         // first pad cycle writes 0x80, then finish_ff marks the zero fill
         if (state_ff == sha_pkg::ST_IDLE && take_req && req_payload.op == sha_pkg::OP_FINISH) begin
            finish_ff    <= 1'b0;
            pad_first_ff <= 1'b1;
         end else if (state_ff == sha_pkg::ST_PAD && pad_first_ff) begin
            finish_ff    <= 1'b1;
            pad_first_ff <= 1'b0;
         end else if (state_ff == sha_pkg::ST_IDLE && take_req) begin
            finish_ff <= finish_in;
         end
         // a wait for the registered ram read comes before the first round
         ram_pref_ff <= (state_in == sha_pkg::ST_ROUND) && (state_ff == sha_pkg::ST_ROUND);
      end
      v_ff    <= v_in;
      w_ff    <= w_in;
      part_ff <= part_in;
   end

endmodule

>>> hw/rtl/sha_ram.sv
// generic single-port-write, one-read synchronous ram with registered read
// depends on nothing
module sha_ram #(
   parameter int unsigned Width = 32,
   parameter int unsigned Depth = 16,
   localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AddrW-1:0] wr_addr,
   input  logic [Width-1:0] wr_data,
   input  logic [AddrW-1:0] rd_addr,
   output logic [Width-1:0] rd_data
);

   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

>>> hw/rtl/sha_checker.sv
// port-level checker for the sha-256 hasher, bound to the top level
// depends on sha_pkg and the macro header
`include "sha256_byte_stream_hasher_unit_macros.svh"
module sha_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input sha_pkg::req_type req_payload,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input sha_pkg::rsp_type rsp_payload
);

   `SHA_ASSERT_IMPL(a_no_overlap, clock, reset, rsp_valid, !req_ready, "request taken during digest")
   `SHA_ASSERT_IMPL(a_last_flag, clock, reset, rsp_valid, rsp_payload.last_word == (rsp_payload.word_index == 3'd7), "last flag mismatch")
   `SHA_ASSERT_NEXT(a_index_step, clock, reset, rsp_valid && rsp_ready && !rsp_payload.last_word, rsp_valid && rsp_payload.word_index == $past(rsp_payload.word_index) + 3'd1, "word index skipped")
   `SHA_ASSERT_NEXT(a_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload), "word changed under stall")

endmodule

bind sha256_byte_stream_hasher_unit sha_checker u_sha_checker (.*);

>>> tb/tb.sv
// testbench for the sha-256 byte stream hasher: predicts digests and checks every word
// depends on sha_pkg and sha256_byte_stream_hasher_unit
`timescale 1ns / 100ps

module tb;

   localparam int WatchdogLimit = 20000;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   sha_pkg::req_type req_payload = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   sha_pkg::rsp_type rsp_payload;

   sha256_byte_stream_hasher_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_payload(rsp_payload)
   );

   always #5 clock = ~clock;

   // predictor state
   logic [31:0]      hash_words [8];
   logic [7:0]       msg_block [64];
   int               pending_bytes;
   logic [63:0]      bit_length;
   sha_pkg::rsp_type digest_queue [$];

   int errors = 0;
   int idle_cycles = 0;
   bit stall_on = 1'b0;

   localparam logic [31:0] H_INIT [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
   localparam logic [31:0] K_TAB [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

   function automatic logic [31:0] ror(logic [31:0] x, int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   function automatic void clear_hash();
      for (int i = 0; i < 8; i++) hash_words[i] = H_INIT[i];
      pending_bytes = 0;
      bit_length = '0;
   endfunction

   // one 64-round compression of msg_block into hash_words
   function automatic void compress_msg_block();
      logic [31:0] w [64];
      logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
      for (int i = 0; i < 16; i++)
         w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
      for (int i = 16; i < 64; i++)
         w[i] = w[i-16] + w[i-7]
              + (ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3))
              + (ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10));
      {a, b, c, d, e, f, g, h} = {hash_words[0], hash_words[1], hash_words[2], hash_words[3],
                                  hash_words[4], hash_words[5], hash_words[6], hash_words[7]};
      for (int i = 0; i < 64; i++) begin
         t1 = h + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + (g ^ (e & (f ^ g))) + K_TAB[i] + w[i];
         t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & b) | (c & (a | b)));
         h = g; g = f; f = e; e = d + t1; d = c; c = b; b = a; a = t1 + t2;
      end
      hash_words[0] += a; hash_words[1] += b; hash_words[2] += c; hash_words[3] += d;
      hash_words[4] += e; hash_words[5] += f; hash_words[6] += g; hash_words[7] += h;
   endfunction

   // advance the predicted hash by one request, queue any digest words
   function automatic void predict_request(sha_pkg::req_type r);
      int i;
      sha_pkg::rsp_type word;
      case (r.op)
         sha_pkg::OP_RESTART: clear_hash();
         sha_pkg::OP_ABSORB: begin
            msg_block[pending_bytes] = r.msg_byte;
            pending_bytes++;
            bit_length += 64'd8;
            if (pending_bytes == 64) begin
               compress_msg_block();
               pending_bytes = 0;
            end
         end
         sha_pkg::OP_FINISH: begin
            i = pending_bytes;
            msg_block[i] = 8'h80;
            i = i + 1;
            if (i > 56) begin
               for (int j = i; j < 64; j++) msg_block[j] = 8'h00;
               compress_msg_block();
               i = 0;
            end
            for (int j = i; j < 56; j++) msg_block[j] = 8'h00;
            for (int k = 0; k < 8; k++) msg_block[56+k] = bit_length[63-8*k -: 8];
            compress_msg_block();
            for (int k = 0; k < 8; k++) begin
               word.digest_word = hash_words[k];
               word.word_index  = k[2:0];
               word.last_word   = (k == 7);
               digest_queue.push_back(word);
            end
            clear_hash();
         end
         default: ;   // unused op is ignored
      endcase
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h expected %h", what, got, want);
      errors++;
   endtask

   // sender: one request, with an optional random gap before a burst
   int burst_left = 0;
   task automatic send_request(logic [1:0] op, logic [7:0] data);
      sha_pkg::req_type r;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 20);
         if ($urandom_range(0, 2) != 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
      end
      burst_left--;
      r.op = op;
      r.msg_byte = data;
      req_valid <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (!req_ready);
      predict_request(r);
   endtask

   task automatic send_message(int len);
      for (int i = 0; i < len; i++) send_request(sha_pkg::OP_ABSORB, 8'($urandom_range(0, 255)));
      send_request(sha_pkg::OP_FINISH, 8'($urandom_range(0, 255)));
   endtask

   // receiver stall pattern and result check
   always @(posedge clock) begin
      sha_pkg::rsp_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (digest_queue.size() == 0) begin
               report_mismatch("unexpected word", rsp_payload.digest_word, 32'h0);
            end else begin
               want = digest_queue.pop_front();
               if (rsp_payload.digest_word !== want.digest_word)
                  report_mismatch("digest_word", rsp_payload.digest_word, want.digest_word);
               if (rsp_payload.word_index !== want.word_index)
                  report_mismatch("word_index", 32'(rsp_payload.word_index),
                                  32'(want.word_index));
               if (rsp_payload.last_word !== want.last_word)
                  report_mismatch("last_word", 32'(rsp_payload.last_word),
                                  32'(want.last_word));
            end
         end
         // stretches of free flow alternate with stretches of random stalls
         if ($urandom_range(0, 63) == 0) stall_on <= ~stall_on;
         rsp_ready <= stall_on ? ($urandom_range(0, 3) == 0) : 1'b1;
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WatchdogLimit) begin
            $display("[sha256_byte_stream_hasher_unit] ERROR");
            $finish;
         end
      end
   end

   task automatic test_directed_extremes();
      send_request(sha_pkg::OP_FINISH, 8'h00);        // empty message
      send_request(sha_pkg::OP_ABSORB, 8'h00);
      send_request(sha_pkg::OP_ABSORB, 8'hff);
      send_request(OP_UNUSED, 8'hff);                 // ignored op
      send_request(sha_pkg::OP_ABSORB, 8'h55);
      send_request(sha_pkg::OP_ABSORB, 8'haa);
      send_request(sha_pkg::OP_FINISH, 8'hff);
      send_request(sha_pkg::OP_ABSORB, 8'h12);
      send_request(sha_pkg::OP_RESTART, 8'h34);       // restart mid-message
      send_request(sha_pkg::OP_ABSORB, 8'h61);
      send_request(sha_pkg::OP_ABSORB, 8'h62);
      send_request(sha_pkg::OP_ABSORB, 8'h63);
      send_request(sha_pkg::OP_FINISH, 8'h00);        // "abc"
   endtask

   task automatic test_padding_boundaries();
      // 55 fits one block, 56 and 63 need a second pad block, 64 is a full block
      send_message(55);
      send_message(56);
      send_message(63);
      send_message(64);
   endtask

   task automatic test_random_stream();
      int sent = 0;
      int len;
      int pick;
      while (sent < 15) begin
         pick = $urandom_range(0, 9);
         if (pick < 8) begin
            len = $urandom_range(0, 12);
            send_message(len);
            sent += len + 1;
         end else if (pick == 8) begin
            send_request(sha_pkg::OP_ABSORB, 8'($urandom_range(0, 255)));
            send_request(sha_pkg::OP_RESTART, 8'($urandom_range(0, 255)));
            sent += 2;
         end else begin
            send_request(OP_UNUSED, 8'($urandom_range(0, 255)));
            sent += 1;
         end
      end
      send_request(sha_pkg::OP_FINISH, 8'h00);
   endtask

   initial begin
      clear_hash();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_directed_extremes();
      test_padding_boundaries();
      test_random_stream();
      req_valid <= 1'b0;
      while (digest_queue.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (errors == 0 && digest_queue.size() == 0) begin
         $display("[sha256_byte_stream_hasher_unit] OK");
      end else begin
         $display("[sha256_byte_stream_hasher_unit] ERROR");
      end
      $finish;
   end
endmodule
